@@ rtl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Constants, codes and types shared by the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned MAX_CHUNKS   = 64;
  localparam int unsigned GRAIN_BYTES  = 8;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned POS_W  = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W  = $clog2(MAX_CHUNKS + 1);

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RESIZE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_MEM   = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;

  localparam logic [SIZE_W-1:0] HDR_SZ   = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_CAP = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

  // One chunk table entry plus its place in the free list
  typedef struct packed {
    logic              present;
    logic              in_use;
    logic [ADDR_W-1:0] offset;
    logic [SIZE_W-1:0] cap;
    logic [SIZE_W-1:0] used;
    logic [POS_W-1:0]  pos;
  } entry_t;

  // Command broadcast to the head logic
  typedef struct packed {
    logic              apply;
    logic              grant;
    logic              rel;
    logic              split;
    logic [SIZE_W-1:0] need;
    logic [ADDR_W-1:0] laddr;
    logic [POS_W-1:0]  gpos;
    logic [POS_W-1:0]  relpos;
    logic [POS_W-1:0]  spos;
    logic [ADDR_W-1:0] new_off;
    logic [SIZE_W-1:0] new_cap;
  } cmd_t;

  // What the head logic sees in the entry passing by
  typedef struct packed {
    logic gcand;
    logic lmatch;
    logic vacant;
    logic fill;
  } probe_t;

endpackage

`default_nettype wire

@@ rtl/ffha_req_if.sv @@
// ----------------------------------------------------------------------------
// ffha_req_if
// Request channel: valid/ready with the request payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [16:0] req_size;
  logic [15:0] data_addr;
  logic        addr_null;

  modport source (output valid, req_type, req_size, data_addr, addr_null, input ready);
  modport sink   (input valid, req_type, req_size, data_addr, addr_null, output ready);
endinterface

`default_nettype wire

@@ rtl/ffha_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffha_rsp_if
// Response channel: valid/ready with the result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_addr;
  logic [1:0]  status;
  logic [16:0] copy_bytes;

  modport source (output valid, result_addr, status, copy_bytes, input ready);
  modport sink   (input valid, result_addr, status, copy_bytes, output ready);
endinterface

`default_nettype wire

@@ rtl/ffha_cell.sv @@
// ----------------------------------------------------------------------------
// ffha_cell
// One ring stage holding a chunk entry; passes it on while the ring turns.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  head_i,
  input  wire                  shift_i,
  input  ffha_pkg::entry_t     d_i,
  output ffha_pkg::entry_t     q_o
);
  import ffha_pkg::*;

  entry_t ent_q, ent_d, init_ent;

  always_comb begin
    init_ent         = '0;
    init_ent.present = head_i;
    init_ent.cap     = head_i ? INIT_CAP : '0;
  end

  assign ent_d = shift_i ? d_i : ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= init_ent;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign q_o = ent_q;

endmodule

`default_nettype wire

@@ rtl/ffha_head.sv @@
// ----------------------------------------------------------------------------
// ffha_head
// Examines and rewrites the entry leaving the head of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_head (
  input  ffha_pkg::entry_t ent_i,
  input  ffha_pkg::cmd_t   cmd_i,
  input  wire              split_pend_i,
  output ffha_pkg::entry_t ent_o,
  output ffha_pkg::probe_t probe_o
);
  import ffha_pkg::*;

  logic is_free;
  logic fill;

  assign is_free = ent_i.present && !ent_i.in_use;

  always_comb begin
    probe_o.gcand  = is_free && (ent_i.cap >= cmd_i.need);
    probe_o.lmatch = ent_i.present && ent_i.in_use &&
                     (({1'b0, ent_i.offset} + HDR_SZ) == {1'b0, cmd_i.laddr});
    probe_o.vacant = !ent_i.present;
    fill           = cmd_i.apply && cmd_i.split && split_pend_i && !ent_i.present;
    probe_o.fill   = fill;

    ent_o = ent_i;
    if (cmd_i.apply) begin
      if (cmd_i.grant && is_free && ent_i.pos == cmd_i.gpos) begin
        ent_o.in_use = 1'b1;
        ent_o.used   = cmd_i.need;
        if (cmd_i.split) ent_o.cap = cmd_i.need;
      end else if (cmd_i.grant && is_free && ent_i.pos > cmd_i.gpos) begin
        // close the gap left by the granted chunk
        ent_o.pos = ent_i.pos - POS_W'(1);
      end
      if (cmd_i.rel && probe_o.lmatch) begin
        ent_o.in_use = 1'b0;
        ent_o.pos    = cmd_i.relpos;
      end
      if (fill) begin
        ent_o.present = 1'b1;
        ent_o.in_use  = 1'b0;
        ent_o.used    = '0;
        ent_o.offset  = cmd_i.new_off;
        ent_o.cap     = cmd_i.new_cap;
        ent_o.pos     = cmd_i.spos;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a rotating ring of chunk table cells.
// ----------------------------------------------------------------------------
// The chunk table lives in a ring of 64 cells that turns one entry per cycle
// past a single head unit while a scan or write-back turn runs. A request is
// taken only while the block is idle. The block takes it, makes one full turn
// of the ring to find the first-fit chunk and the chunk being released or
// resized, decides, and makes a second full turn to write the changes back
// when the table changes; then it loads the response register once that
// register is free. The second turn is skipped when nothing changes (errors,
// type 3, resize in place). The response register lets the next request start
// while a result still waits to be taken.
`default_nettype none

module first_fit_heap_allocator (
  input  wire         clk_i,
  input  wire         rst_ni,
  ffha_req_if.sink    req_i,
  ffha_rsp_if.source  rsp_o
);
  import ffha_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0] state_q, state_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] fc_q, fc_d;

  // latched request
  logic [1:0]        type_q;
  logic [SIZE_W-1:0] size_q;
  logic [ADDR_W-1:0] addr_q;
  logic              null_q;
  logic [SIZE_W-1:0] need_q;

  // scan results
  logic              fg_q, fl_q, empty_q;
  logic [POS_W-1:0]  gpos_q;
  logic [ADDR_W-1:0] goff_q;
  logic [SIZE_W-1:0] gcap_q, lcap_q, lused_q;

  // decision
  logic              grant_q, rel_q, split_q, pend_q;
  logic [POS_W-1:0]  relpos_q, spos_q;
  logic [ADDR_W-1:0] noff_q, res_q;
  logic [SIZE_W-1:0] ncap_q, copy_q;
  logic [1:0]        st_q;

  // response register
  logic              rv_q;
  logic [ADDR_W-1:0] raddr_q;
  logic [1:0]        rst_q;
  logic [SIZE_W-1:0] rcopy_q;

  entry_t cell_q [MAX_CHUNKS];
  entry_t head_out;
  cmd_t   cmd;
  probe_t probe;
  logic   shift;
  logic   accept;

  assign shift  = (state_q == S_SCAN) || (state_q == S_APPLY);
  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  for (genvar i = 0; i < MAX_CHUNKS; i++) begin : g_ring
    entry_t din;
    if (i == MAX_CHUNKS - 1) begin : g_last
      assign din = head_out;
    end else begin : g_mid
      assign din = cell_q[i+1];
    end
    ffha_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .head_i  (i == 0),
      .shift_i (shift),
      .d_i     (din),
      .q_o     (cell_q[i])
    );
  end

  always_comb begin
    cmd.apply   = (state_q == S_APPLY);
    cmd.grant   = grant_q;
    cmd.rel     = rel_q;
    cmd.split   = split_q;
    cmd.need    = need_q;
    cmd.laddr   = addr_q;
    cmd.gpos    = gpos_q;
    cmd.relpos  = relpos_q;
    cmd.spos    = spos_q;
    cmd.new_off = noff_q;
    cmd.new_cap = ncap_q;
  end

  ffha_head u_head (
    .ent_i        (cell_q[0]),
    .cmd_i        (cmd),
    .split_pend_i (pend_q),
    .ent_o        (head_out),
    .probe_o      (probe)
  );

  // decision terms
  logic is_grant, is_rel, is_rsz, do_split, act_grant, act_rel;
  logic [SIZE_W:0] split_min;
  logic [1:0] st_n;
  logic [ADDR_W-1:0] res_n;
  logic [SIZE_W-1:0] copy_n;

  always_comb begin
    is_grant  = (type_q == REQ_ALLOC) || (type_q == REQ_RESIZE && null_q);
    is_rel    = (type_q == REQ_RELEASE);
    is_rsz    = (type_q == REQ_RESIZE) && !null_q;
    split_min = {1'b0, need_q} + (SIZE_W+1)'(HEADER_BYTES + GRAIN_BYTES);
    do_split  = ({1'b0, gcap_q} >= split_min) && empty_q;
    act_grant = 1'b0;
    act_rel   = 1'b0;
    st_n      = ST_OK;
    res_n     = '0;
    copy_n    = '0;
    if (is_grant) begin
      if (fg_q) begin
        act_grant = 1'b1;
        res_n     = ADDR_W'({1'b0, goff_q} + HDR_SZ);
      end else begin
        st_n = ST_NO_MEM;
      end
    end else if (is_rel) begin
      if (fl_q) act_rel = 1'b1;
      else st_n = ST_NOT_USED;
    end else if (is_rsz) begin
      if (!fl_q) begin
        st_n = ST_NOT_USED;
      end else if (size_q <= lcap_q) begin
        res_n = addr_q;
      end else if (fg_q) begin
        act_grant = 1'b1;
        act_rel   = 1'b1;
        res_n     = ADDR_W'({1'b0, goff_q} + HDR_SZ);
        copy_n    = lused_q;
      end else begin
        st_n = ST_NO_MEM;
      end
    end
  end

  logic [SIZE_W-1:0] raw1;
  logic [SIZE_W:0]   need_n;
  assign raw1   = (req_i.req_size == '0) ? SIZE_W'(1) : req_i.req_size;
  assign need_n = ({1'b0, raw1} + (SIZE_W+1)'(GRAIN_BYTES - 1)) &
                  ~(SIZE_W+1)'(GRAIN_BYTES - 1);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fc_d    = fc_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_SCAN;
          cnt_d   = '0;
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + POS_W'(1);
        if (cnt_q == POS_W'(MAX_CHUNKS - 1)) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cnt_d   = '0;
        state_d = (act_grant || act_rel) ? S_APPLY : S_FIN;
      end
      S_APPLY: begin
        cnt_d = cnt_q + POS_W'(1);
        if (cnt_q == POS_W'(MAX_CHUNKS - 1)) begin
          state_d = S_FIN;
          fc_d    = fc_q - CNT_W'(grant_q) + CNT_W'(split_q) + CNT_W'(rel_q);
        end
      end
      S_FIN: begin
        if (!rv_q || rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      fc_q    <= CNT_W'(1);
      rv_q    <= 1'b0;
      grant_q <= 1'b0;
      rel_q   <= 1'b0;
      split_q <= 1'b0;
      pend_q  <= 1'b0;
      fg_q    <= 1'b0;
      fl_q    <= 1'b0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fc_q    <= fc_d;
      if (rv_q && rsp_o.ready) rv_q <= 1'b0;
      if (state_q == S_FIN && (!rv_q || rsp_o.ready)) rv_q <= 1'b1;
      if (accept) begin
        fg_q    <= 1'b0;
        fl_q    <= 1'b0;
        empty_q <= 1'b0;
      end
      if (state_q == S_SCAN) begin
        if (probe.gcand && (!fg_q || cell_q[0].pos < gpos_q)) fg_q <= 1'b1;
        if (probe.lmatch) fl_q <= 1'b1;
        if (probe.vacant) empty_q <= 1'b1;
      end
      if (state_q == S_DECIDE) begin
        grant_q <= act_grant;
        rel_q   <= act_rel;
        split_q <= act_grant && do_split;
        pend_q  <= 1'b1;
      end
      if (state_q == S_APPLY && probe.fill) pend_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q <= req_i.req_type;
      size_q <= req_i.req_size;
      addr_q <= req_i.data_addr;
      null_q <= req_i.addr_null;
      // saturate a rounded size past the field; it can never fit the heap
      need_q <= need_n[SIZE_W] ? '1 : need_n[SIZE_W-1:0];
    end
    if (state_q == S_SCAN) begin
      if (probe.gcand && (!fg_q || cell_q[0].pos < gpos_q)) begin
        gpos_q <= cell_q[0].pos;
        goff_q <= cell_q[0].offset;
        gcap_q <= cell_q[0].cap;
      end
      if (probe.lmatch) begin
        lcap_q  <= cell_q[0].cap;
        lused_q <= cell_q[0].used;
      end
    end
    if (state_q == S_DECIDE) begin
      st_q    <= st_n;
      res_q   <= res_n;
      copy_q  <= copy_n;
      noff_q  <= ADDR_W'(goff_q + ADDR_W'(HEADER_BYTES) + need_q[ADDR_W-1:0]);
      ncap_q  <= gcap_q - need_q - HDR_SZ;
      // split tail lands at the end of the list after the drop
      spos_q  <= POS_W'(fc_q - CNT_W'(1));
      relpos_q <= (act_grant && !do_split) ? POS_W'(fc_q - CNT_W'(1)) : POS_W'(fc_q);
    end
    if (state_q == S_FIN && (!rv_q || rsp_o.ready)) begin
      raddr_q <= res_q;
      rst_q   <= st_q;
      rcopy_q <= copy_q;
    end
  end

  assign rsp_o.valid       = rv_q;
  assign rsp_o.result_addr = raddr_q;
  assign rsp_o.status      = rst_q;
  assign rsp_o.copy_bytes  = rcopy_q;

endmodule

`default_nettype wire

@@ rtl/ffha_checker.sv @@
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the allocator response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        rsp_valid_i,
  input wire        rsp_ready_i,
  input wire [15:0] result_addr_i,
  input wire [1:0]  status_i,
  input wire [16:0] copy_bytes_i
);
  import ffha_pkg::*;

  // hold a response until it is transferred
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(result_addr_i)
      && $stable(status_i) && $stable(copy_bytes_i))
    else $error("response dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (status_i == ST_OK || status_i == ST_NO_MEM || status_i == ST_NOT_USED))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> result_addr_i == '0 && copy_bytes_i == '0)
    else $error("error response carries an address or copy count");

  a_copy_grain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && copy_bytes_i != '0 |-> copy_bytes_i[2:0] == 3'd0
      && result_addr_i >= 16'(HEADER_BYTES))
    else $error("copy count not on grain or moved address invalid");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .result_addr_i (rsp_o.result_addr),
  .status_i      (rsp_o.status),
  .copy_bytes_i  (rsp_o.copy_bytes)
);

`default_nettype wire

@@ sim/first_fit_heap_allocator_test.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// Self-checking bench for the first-fit heap allocator: a directed table,
// then random allocate/release/resize and unused-type traffic checked against
// a chunk-table predictor, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned N_RANDOM = 930;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  st;
    logic [16:0] copy;
  } heap_rsp_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] size;
    logic [15:0] addr;
    logic        is_null;
    logic        typed;
    heap_rsp_t   rsp;
  } heap_row_t;

  logic clk_i;
  logic rst_ni;

  ffha_req_if req_if ();
  ffha_rsp_if rsp_if ();

  first_fit_heap_allocator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Chunk table mirror
  int unsigned tbl_off  [MAX_CHUNKS];
  int unsigned tbl_cap  [MAX_CHUNKS];
  int unsigned tbl_used [MAX_CHUNKS];
  bit          tbl_busy [MAX_CHUNKS];
  bit          tbl_live [MAX_CHUNKS];
  int unsigned free_list[MAX_CHUNKS];
  int unsigned free_len;

  heap_rsp_t pending_rsp[$];
  int unsigned n_mismatch, n_checked, n_ok, n_nomem, n_notused, n_moved;
  int unsigned idle_cycles;
  bit          stim_done;

  function automatic void heap_clear();
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      tbl_off[i] = 0; tbl_cap[i] = 0; tbl_used[i] = 0;
      tbl_busy[i] = 0; tbl_live[i] = 0; free_list[i] = 0;
    end
    tbl_live[0] = 1;
    tbl_cap[0]  = HEAP_BYTES - HEADER_BYTES;
    free_len    = 1;
  endfunction

  function automatic void free_push(int unsigned e);
    if (free_len < MAX_CHUNKS) begin
      free_list[free_len] = e;
      free_len++;
    end
  endfunction

  function automatic bit heap_grant(int unsigned raw, output int unsigned addr);
    int unsigned need, e, s;
    need = ((raw == 0 ? 1 : raw) + 7) & ~32'd7;
    addr = 0;
    for (int p = 0; p < free_len; p++) begin
      e = free_list[p];
      if (tbl_cap[e] < need) continue;
      if (tbl_cap[e] >= need + HEADER_BYTES + 8) begin
        s = MAX_CHUNKS;
        for (int k = MAX_CHUNKS - 1; k >= 0; k--)
          if (!tbl_live[k]) s = k;
        if (s < MAX_CHUNKS) begin
          tbl_live[s] = 1; tbl_busy[s] = 0; tbl_used[s] = 0;
          tbl_off[s] = tbl_off[e] + HEADER_BYTES + need;
          tbl_cap[s] = tbl_cap[e] - need - HEADER_BYTES;
          tbl_cap[e] = need;
          free_push(s);
        end
      end
      tbl_busy[e] = 1;
      tbl_used[e] = need;
      for (int i = p; i + 1 < free_len; i++) free_list[i] = free_list[i + 1];
      free_len--;
      addr = (tbl_off[e] + HEADER_BYTES) & 16'hFFFF;
      return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned heap_find(int unsigned addr);
    for (int e = 0; e < MAX_CHUNKS; e++)
      if (tbl_live[e] && tbl_busy[e] && tbl_off[e] + HEADER_BYTES == addr) return e;
    return MAX_CHUNKS;
  endfunction

  function automatic heap_rsp_t heap_apply(logic [1:0] kind, logic [16:0] size,
                                           logic [15:0] addr, logic is_null);
    heap_rsp_t r;
    int unsigned e, got;
    r = '0;
    if (kind == REQ_ALLOC || (kind == REQ_RESIZE && is_null)) begin
      if (heap_grant(size, got)) r.addr = got;
      else r.st = ST_NO_MEM;
    end else if (kind == REQ_RELEASE) begin
      e = heap_find(addr);
      if (e >= MAX_CHUNKS) r.st = ST_NOT_USED;
      else begin
        tbl_busy[e] = 0;
        free_push(e);
      end
    end else if (kind == REQ_RESIZE) begin
      e = heap_find(addr);
      if (e >= MAX_CHUNKS) r.st = ST_NOT_USED;
      else if (size <= tbl_cap[e]) r.addr = addr;
      else if (heap_grant(size, got)) begin
        r.addr = got;
        r.copy = tbl_used[e];
        tbl_busy[e] = 0;
        free_push(e);
      end else r.st = ST_NO_MEM;
    end
    return r;
  endfunction

  // Data address of a random in-use chunk, or a random offset when none is held
  function automatic logic [15:0] live_addr();
    int unsigned hits[$];
    for (int e = 0; e < MAX_CHUNKS; e++)
      if (tbl_live[e] && tbl_busy[e]) hits.push_back(tbl_off[e] + HEADER_BYTES);
    if (hits.size() == 0) return 16'($urandom);
    return 16'(hits[$urandom_range(0, hits.size() - 1)]);
  endfunction

  function automatic heap_row_t random_row();
    heap_row_t row;
    int unsigned pick;
    row = '0;
    row.kind = REQ_ALLOC;
    row.is_null = 1'($urandom);
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:       row.size = 17'($urandom_range(0, 65536));
      1, 2:    row.size = 17'($urandom_range(0, 4096));
      default: row.size = 17'($urandom_range(0, 256));
    endcase
    row.addr = live_addr();
    if (pick < 40) begin
      row.kind = REQ_ALLOC;
    end else if (pick < 70) begin
      row.kind = REQ_RELEASE;
      if ($urandom_range(0, 9) == 0) row.addr = 16'($urandom);
    end else if (pick < 96) begin
      row.kind = REQ_RESIZE;
      row.is_null = ($urandom_range(0, 6) == 0);
      if ($urandom_range(0, 7) == 0) row.addr = 16'($urandom);
      if ($urandom_range(0, 3) == 0) row.size = 17'($urandom_range(0, 64));
    end else begin
      row.kind = REQ_UNUSED;
      row.size = 17'($urandom);
      row.addr = 16'($urandom);
    end
    return row;
  endfunction

  heap_row_t directed_rows[] = '{
    '{REQ_ALLOC,   17'd0,     16'd0,      1'b0, 1'b1, '{16'd32, ST_OK, 17'd0}},
    '{REQ_RELEASE, 17'd0,     16'd32,     1'b0, 1'b1, '{16'd0, ST_OK, 17'd0}},
    '{REQ_RELEASE, 17'd0,     16'd32,     1'b0, 1'b1, '{16'd0, ST_NOT_USED, 17'd0}},
    '{REQ_ALLOC,   17'd65536, 16'd0,      1'b0, 1'b1, '{16'd0, ST_NO_MEM, 17'd0}},
    '{REQ_UNUSED,  17'h1FFFF, 16'hFFFF,   1'b1, 1'b1, '{16'd0, ST_OK, 17'd0}},
    '{REQ_RELEASE, 17'h1FFFF, 16'hFFFF,   1'b1, 1'b1, '{16'd0, ST_NOT_USED, 17'd0}},
    '{REQ_RESIZE,  17'd0,     16'h8000,   1'b0, 1'b1, '{16'd0, ST_NOT_USED, 17'd0}},
    '{REQ_RESIZE,  17'd100,   16'd0,      1'b1, 1'b0, '0},
    '{REQ_ALLOC,   17'd1,     16'd0,      1'b0, 1'b0, '0},
    '{REQ_RESIZE,  17'd104,   16'd72,     1'b0, 1'b0, '0},
    '{REQ_RESIZE,  17'd105,   16'd72,     1'b0, 1'b0, '0},
    '{REQ_RESIZE,  17'd65536, 16'd208,    1'b0, 1'b0, '0},
    '{REQ_ALLOC,   17'd65504, 16'd0,      1'b0, 1'b0, '0},
    '{REQ_RELEASE, 17'd0,     16'd208,    1'b0, 1'b0, '0},
    '{REQ_RELEASE, 17'd0,     16'd32,     1'b0, 1'b0, '0},
    '{REQ_RESIZE,  17'd65536, 16'd0,      1'b1, 1'b0, '0},
    '{REQ_ALLOC,   17'd8,     16'd0,      1'b0, 1'b0, '0},
    '{REQ_ALLOC,   17'd9,     16'd0,      1'b0, 1'b0, '0}
  };

  task automatic send_row(heap_row_t row, int unsigned gap);
    heap_rsp_t predicted;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= row.kind;
    req_if.req_size  <= row.size;
    req_if.data_addr <= row.addr;
    req_if.addr_null <= row.is_null;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = heap_apply(row.kind, row.size, row.addr, row.is_null);
    pending_rsp.push_back(row.typed ? row.rsp : predicted);
  endtask

  task automatic drain_all();
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  // Request side
  initial begin
    bit burst;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_ALLOC;
    req_if.req_size  = '0;
    req_if.data_addr = '0;
    req_if.addr_null = 1'b0;
    stim_done = 0;
    heap_clear();
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_row(directed_rows[i], draw_gap(0));
    // hold off until every result is back
    drain_all();
    burst = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 60 == 0) burst = ($urandom_range(0, 3) == 0);
      if (i == N_RANDOM / 2) drain_all();
      send_row(random_row(), draw_gap(burst));
    end
    req_if.valid <= 1'b0;
    stim_done = 1;
  end

  // Response side
  initial begin
    int unsigned stall;
    heap_rsp_t want, seen;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      seen = '{rsp_if.result_addr, rsp_if.status, rsp_if.copy_bytes};
      n_checked++;
      if (pending_rsp.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("ERROR: unexpected result addr=%0d status=%0d copy=%0d",
                   seen.addr, seen.st, seen.copy);
      end else begin
        want = pending_rsp.pop_front();
        case (want.st)
          ST_NO_MEM:   n_nomem++;
          ST_NOT_USED: n_notused++;
          default:     n_ok++;
        endcase
        if (want.copy != 0) n_moved++;
        if (seen !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: result %0d expected addr=%0d status=%0d copy=%0d, got addr=%0d status=%0d copy=%0d",
                     n_checked, want.addr, want.st, want.copy, seen.addr, seen.st, seen.copy);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    n_mismatch = 0; n_checked = 0; n_ok = 0; n_nomem = 0; n_notused = 0; n_moved = 0;
    idle_cycles = 0;
    fork
      begin
        wait (stim_done && pending_rsp.size() == 0);
        repeat (300) @(posedge clk_i);
      end
      begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
        n_mismatch++;
      end
    join_any
    if (pending_rsp.size() != 0) begin
      $display("ERROR: %0d results never arrived", pending_rsp.size());
      n_mismatch++;
    end
    $display("Checked %0d results: %0d ok, %0d out of memory, %0d not in use, %0d moved",
             n_checked, n_ok, n_nomem, n_notused, n_moved);
    if (n_mismatch == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
rtl/ffha_pkg.sv
rtl/ffha_req_if.sv
rtl/ffha_rsp_if.sv
rtl/ffha_cell.sv
rtl/ffha_head.sv
rtl/first_fit_heap_allocator.sv
rtl/ffha_checker.sv
sim/first_fit_heap_allocator_test.sv
